// ===== rtl/ipd_pkg.sv =====
// ----------------------------------------------------------------------------
// ipd_pkg - shared types and constants of the despeckle filter
// Register map, candidate codes and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package ipd_pkg;

	// Default sizes
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 8;

	// Frame size registers
	localparam int FW_BITS = 11;
	localparam int FH_BITS = 12;
	localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(30);
	localparam logic [FH_BITS-1:0] FH_RESET = FH_BITS'(20);

	// Configuration bus
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam int REG_IDX_LSB   = 2;
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Which pixel the shared judge unit works on
	typedef enum logic [1:0] {
		CAND_MAIN,   // row above, centred under the incoming column
		CAND_TAIL,   // last row, pixel left of the incoming one
		CAND_CORNER  // last row, the incoming last-column pixel itself
	} cand_t;

	typedef struct packed {
		logic  start;    // capture item, issue first line store reads
		logic  fetch_b;  // capture first reads, issue second reads
		logic  commit;   // capture second reads, write stores, advance counters
		logic  judge;    // load judge stage with the chosen candidate
		logic  emit;     // load output register from judge stage
		logic  last;     // result being emitted closes the run
		cand_t cand;
	} cmd_t;

	typedef struct packed {
		logic has_main;
		logic has_tail;
		logic has_corner;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/ipd_ifs.sv =====
// ----------------------------------------------------------------------------
// ipd_ifs - stream channels of the despeckle filter
// Valid/ready channels for incoming pixels and for filtered results.
// ----------------------------------------------------------------------------
interface ipd_pix_if import ipd_pkg::*; #(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink   (input valid, input pixel_in, output ready);
endinterface

interface ipd_res_if import ipd_pkg::*; #(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_out;
	logic                  was_replaced;
	logic                  end_of_row;
	logic                  end_of_frame;
	logic                  last_of_run;

	modport source (
		output valid, output pixel_out, output was_replaced,
		output end_of_row, output end_of_frame, output last_of_run,
		input ready
	);
	modport sink (
		input valid, input pixel_out, input was_replaced,
		input end_of_row, input end_of_frame, input last_of_run,
		output ready
	);
endinterface

// ===== rtl/isolated_pixel_despeckle_filter.sv =====
// ----------------------------------------------------------------------------
// isolated_pixel_despeckle_filter - four-neighbour isolated pixel filter
// Replaces a pixel that differs from all its in-frame neighbours by their
// truncated average; output trails input by one row.
// ----------------------------------------------------------------------------
// Usage:
//  - pixel_stream takes the pixels of a frame in raster order, one item per
//    handshake. result_stream gives filtered pixels in raster order with
//    end-of-row, end-of-frame and last-of-run marks.
//  - Items of row 0 give no result; an item of row r > 0 gives pixel (r-1,c).
//    On the last row an item also gives the pixel to its left, and the
//    last-column item gives itself too, so one item gives up to three results.
//  - An item goes through two read rounds on the dual-read line stores and
//    write-back, then one pass of the shared judge/average unit and output
//    load per result. The next item is accepted only once every result of
//    the item has been loaded into the output register.
//  - A result waits in the output register while the next item is accepted.
//    A stalled receiver holds the output and the controller waits before
//    loading the following result of the same run.
//  - Reset clears the counters and sets width 30, height 20. The line stores
//    need no clearing pass: each entry is written before it is read.
//  - Frame width and height are written over the APB port between items.
// ----------------------------------------------------------------------------
module isolated_pixel_despeckle_filter import ipd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	ipd_pix_if.sink                  pixel_stream,
	ipd_res_if.source                result_stream,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	logic [FW_BITS-1:0] frame_width;
	logic [FH_BITS-1:0] frame_height;
	logic               in_ready;
	cmd_t               cmd;
	sts_t               sts;

	// frame size registers
	ipd_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.frame_width  (frame_width),
		.frame_height (frame_height)
	);

	// item sequencer: accept, read, write back, then judge and emit each result
	ipd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel_stream.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign pixel_stream.ready = in_ready;

	// line stores, counters, judge unit and output register
	ipd_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_width   (frame_width),
		.frame_height  (frame_height),
		.pixel_in      (pixel_stream.pixel_in),
		.cmd           (cmd),
		.sts           (sts),
		.result_stream (result_stream)
	);

endmodule

// ===== rtl/ipd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ipd_cfg_regs - frame size registers
// APB-style slave holding frame width and frame height.
// ----------------------------------------------------------------------------
module ipd_cfg_regs import ipd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output logic [FW_BITS-1:0]       frame_width,
	output logic [FH_BITS-1:0]       frame_height
);

	logic               wr_en;
	logic [FW_BITS-1:0] frame_width_q;
	logic [FH_BITS-1:0] frame_height_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else if (wr_en) begin
			unique case (paddr[REG_IDX_LSB])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[REG_IDX_LSB])
			REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(frame_height_q);
		endcase
	end

	assign frame_width  = frame_width_q;
	assign frame_height = frame_height_q;

endmodule

// ===== rtl/ipd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipd_ctrl - sequencing of one pixel item
// Steps through the line store reads, the write-back and one judge/emit pass
// for each result the item causes.
// ----------------------------------------------------------------------------
module ipd_ctrl import ipd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FETCH  = 3'd1;
	localparam logic [2:0] S_COMMIT = 3'd2;
	localparam logic [2:0] S_JUDGE  = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0] state_q, state_d;
	cand_t      cand_q, cand_d;
	logic       first_ok, more_ok;
	cand_t      first_cand, more_cand;

	// first candidate after write-back
	always_comb begin
		first_ok   = 1'b1;
		first_cand = CAND_MAIN;
		if (!sts.has_main) begin
			if (sts.has_tail) begin
				first_cand = CAND_TAIL;
			end else if (sts.has_corner) begin
				first_cand = CAND_CORNER;
			end else begin
				first_ok = 1'b0;
			end
		end
	end

	// candidate following the current one
	always_comb begin
		more_ok   = 1'b0;
		more_cand = CAND_CORNER;
		case (cand_q)
			CAND_MAIN: begin
				if (sts.has_tail) begin
					more_ok   = 1'b1;
					more_cand = CAND_TAIL;
				end else if (sts.has_corner) begin
					more_ok = 1'b1;
				end
			end
			CAND_TAIL: more_ok = sts.has_corner;
			default:   more_ok = 1'b0;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.cand = cand_q;
		in_ready = 1'b0;
		state_d  = state_q;
		cand_d   = cand_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_FETCH;
				end
			end
			S_FETCH: begin
				cmd.fetch_b = 1'b1;
				state_d     = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				if (first_ok) begin
					cand_d  = first_cand;
					state_d = S_JUDGE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_JUDGE: begin
				cmd.judge = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = !more_ok;
					if (more_ok) begin
						cand_d  = more_cand;
						state_d = S_JUDGE;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cand_q  <= CAND_MAIN;
		end else begin
			state_q <= state_d;
			cand_q  <= cand_d;
		end
	end

endmodule

// ===== rtl/ipd_datapath.sv =====
// ----------------------------------------------------------------------------
// ipd_datapath - line stores, counters, judge unit and output register
// Holds the two previous rows, gathers the four-neighbour window of each
// candidate and replaces isolated pixels by the truncated neighbour average.
// ----------------------------------------------------------------------------
module ipd_datapath import ipd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [FW_BITS-1:0]    frame_width,
	input  logic [FH_BITS-1:0]    frame_height,
	input  logic [PIXEL_BITS-1:0] pixel_in,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	ipd_res_if.source             result_stream
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = ($clog2(MAX_WIDTH + 1) > FW_BITS) ? $clog2(MAX_WIDTH + 1) : FW_BITS;
	localparam int SW = PIXEL_BITS + 2;
	localparam int PW = 2 * SW + 1;
	// floor(x/3) == (x * M3) >> S3 for every x below 2**SW
	localparam int S3     = SW + 1;
	localparam int M3_INT = ((1 << S3) + 2) / 3;
	localparam logic [SW:0] M3 = M3_INT[SW:0];

	// frame geometry
	logic [EW-1:0]      fw_ext, w_eff;
	logic [CW-1:0]      wm1, c_cl;
	logic [FH_BITS-1:0] h_eff, hm1;
	logic               last_row, last_col;

	// counters
	logic [CW-1:0]         col_q;
	logic [FH_BITS-1:0]    row_q;
	logic [PIXEL_BITS-1:0] pend_q;

	// item capture
	logic [PIXEL_BITS-1:0] px_q, pend_old_q;
	logic [CW-1:0]         c_q;
	logic                  lrow_q, lcol_q, rgt0_q, rgt1_q, cgt0_q, cgt1_q;
	logic [PIXEL_BITS-1:0] centre_q, right_q, up_q, left_q, prevm1_q, prevm2_q;

	// line stores
	logic [PIXEL_BITS-1:0] prev_mem  [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] prev2_mem [MAX_WIDTH];
	logic [CW-1:0]         prev_ra0, prev_ra1, prev2_ra0, prev2_ra1;
	logic [PIXEL_BITS-1:0] prev_rd0, prev_rd1, prev2_rd0, prev2_rd1;

	// judge unit
	logic [PIXEL_BITS-1:0] sel_centre;
	logic [PIXEL_BITS-1:0] sel_nb [4];
	logic [3:0]            sel_has;
	logic                  sel_eor, sel_eof;
	logic                  mt;
	logic [SW-1:0]         sm;
	logic [2:0]            ct;
	logic [PIXEL_BITS-1:0] jc_centre_q;
	logic [SW-1:0]         jc_sum_q;
	logic [2:0]            jc_cnt_q;
	logic                  jc_match_q, jc_eor_q, jc_eof_q;
	logic [PW-1:0]         prod;
	logic [PIXEL_BITS-1:0] avg;
	logic                  rep;

	// output register
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] out_pix_q;
	logic                  out_rep_q, out_eor_q, out_eof_q, out_last_q;

	// effective sizes and the clamped column
	always_comb begin
		fw_ext = EW'(frame_width);
		if (fw_ext < EW'(2)) begin
			w_eff = EW'(2);
		end else if (fw_ext > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = fw_ext;
		end
		wm1      = CW'(w_eff - EW'(1));
		c_cl     = (col_q > wm1) ? wm1 : col_q;
		h_eff    = (frame_height < FH_BITS'(2)) ? FH_BITS'(2) : frame_height;
		hm1      = h_eff - FH_BITS'(1);
		last_row = (row_q >= hm1);
		last_col = (c_cl == wm1);
	end

	// read addresses: first round right/centre/up/left, second round two to the left
	always_comb begin
		if (cmd.start) begin
			prev_ra0  = c_cl;
			prev_ra1  = c_cl + CW'(1);
			prev2_ra0 = c_cl;
			prev2_ra1 = c_cl - CW'(1);
		end else begin
			prev_ra0  = c_q - CW'(1);
			prev_ra1  = c_q - CW'(2);
			prev2_ra0 = c_q;
			prev2_ra1 = c_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			prev_mem[c_q]  <= px_q;
			prev2_mem[c_q] <= centre_q;
		end
		prev_rd0  <= prev_mem[prev_ra0];
		prev_rd1  <= prev_mem[prev_ra1];
		prev2_rd0 <= prev2_mem[prev2_ra0];
		prev2_rd1 <= prev2_mem[prev2_ra1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (cmd.commit) begin
			if (lcol_q) begin
				col_q <= '0;
				row_q <= lrow_q ? '0 : row_q + FH_BITS'(1);
			end else begin
				col_q <= c_q + CW'(1);
			end
			if (lrow_q) begin
				pend_q <= px_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q       <= pixel_in;
			pend_old_q <= pend_q;
			c_q        <= c_cl;
			lrow_q     <= last_row;
			lcol_q     <= last_col;
			rgt0_q     <= (row_q != '0);
			rgt1_q     <= (row_q > FH_BITS'(1));
			cgt0_q     <= (c_cl != '0);
			cgt1_q     <= (c_cl > CW'(1));
		end
		if (cmd.fetch_b) begin
			centre_q <= prev_rd0;
			right_q  <= prev_rd1;
			up_q     <= prev2_rd0;
			left_q   <= prev2_rd1;
		end
		if (cmd.commit) begin
			prevm1_q <= prev_rd0;
			prevm2_q <= prev_rd1;
		end
	end

	// neighbour order: bit 0 right, 1 left, 2 up, 3 down
	always_comb begin
		unique case (cmd.cand)
			CAND_MAIN: begin
				sel_centre = centre_q;
				sel_nb[0]  = right_q;
				sel_nb[1]  = left_q;
				sel_nb[2]  = up_q;
				sel_nb[3]  = px_q;
				sel_has    = {1'b1, rgt1_q, cgt0_q, !lcol_q};
				sel_eor    = lcol_q;
				sel_eof    = 1'b0;
			end
			CAND_TAIL: begin
				sel_centre = pend_old_q;
				sel_nb[0]  = px_q;
				sel_nb[1]  = prevm2_q;
				sel_nb[2]  = left_q;
				sel_nb[3]  = px_q;
				sel_has    = {1'b0, 1'b1, cgt1_q, 1'b1};
				sel_eor    = 1'b0;
				sel_eof    = 1'b0;
			end
			default: begin
				sel_centre = px_q;
				sel_nb[0]  = px_q;
				sel_nb[1]  = prevm1_q;
				sel_nb[2]  = centre_q;
				sel_nb[3]  = px_q;
				sel_has    = {1'b0, 1'b1, cgt0_q, 1'b0};
				sel_eor    = 1'b1;
				sel_eof    = 1'b1;
			end
		endcase
	end

	always_comb begin
		mt = 1'b0;
		sm = '0;
		ct = '0;
		for (int i = 0; i < 4; i++) begin
			if (sel_has[i]) begin
				if (sel_nb[i] == sel_centre) begin
					mt = 1'b1;
				end else begin
					sm = sm + SW'(sel_nb[i]);
					ct = ct + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.judge) begin
			jc_centre_q <= sel_centre;
			jc_sum_q    <= sm;
			jc_cnt_q    <= ct;
			jc_match_q  <= mt;
			jc_eor_q    <= sel_eor;
			jc_eof_q    <= sel_eof;
		end
	end

	// truncated average over one to four neighbours
	assign prod = PW'(jc_sum_q) * PW'(M3);

	always_comb begin
		case (jc_cnt_q)
			3'd2:    avg = jc_sum_q[1 +: PIXEL_BITS];
			3'd3:    avg = prod[S3 +: PIXEL_BITS];
			3'd4:    avg = jc_sum_q[2 +: PIXEL_BITS];
			default: avg = jc_sum_q[PIXEL_BITS-1:0];
		endcase
		rep = !jc_match_q && (jc_cnt_q != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_pix_q  <= rep ? avg : jc_centre_q;
			out_rep_q  <= rep;
			out_eor_q  <= jc_eor_q;
			out_eof_q  <= jc_eof_q;
			out_last_q <= cmd.last;
		end
	end

	assign result_stream.valid        = out_valid_q;
	assign result_stream.pixel_out    = out_pix_q;
	assign result_stream.was_replaced = out_rep_q;
	assign result_stream.end_of_row   = out_eor_q;
	assign result_stream.end_of_frame = out_eof_q;
	assign result_stream.last_of_run  = out_last_q;

	assign sts.has_main   = rgt0_q;
	assign sts.has_tail   = lrow_q && cgt0_q;
	assign sts.has_corner = lrow_q && lcol_q;
	assign sts.out_free   = !out_valid_q || result_stream.ready;

endmodule

// ===== rtl/ipd_checker.sv =====
// ----------------------------------------------------------------------------
// ipd_checker - port-level checks of the despeckle filter
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module ipd_checker import ipd_pkg::*; #(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [PIXEL_BITS-1:0] pixel_out,
	input logic                  was_replaced,
	input logic                  end_of_row,
	input logic                  end_of_frame,
	input logic                  last_of_run
);

	logic in_accept;

	assign in_accept = in_valid && in_ready;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({pixel_out, was_replaced, end_of_row,
			end_of_frame, last_of_run}))
		else $error("result payload changed while stalled");

	// no new item while a run still has results to come
	a_run_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !in_accept)
		else $error("item accepted in the middle of a run");

	// a fresh result is only loaded while the input side is held off
	a_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result loaded while input side was open");

endmodule

bind isolated_pixel_despeckle_filter ipd_checker #(
	.PIXEL_BITS (PIXEL_BITS)
) u_ipd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pixel_stream.valid),
	.in_ready     (pixel_stream.ready),
	.out_valid    (result_stream.valid),
	.out_ready    (result_stream.ready),
	.pixel_out    (result_stream.pixel_out),
	.was_replaced (result_stream.was_replaced),
	.end_of_row   (result_stream.end_of_row),
	.end_of_frame (result_stream.end_of_frame),
	.last_of_run  (result_stream.last_of_run)
);

// ===== tb/ipd_result_checker.sv =====
// ----------------------------------------------------------------------------
// ipd_result_checker - prediction and comparison for the despeckle filter
// Watches the pixel and result channels and the register port, keeps its own
// line stores, counters and frame size, works out the filtered pixels each
// accepted item must cause and compares every result field by field.
// ----------------------------------------------------------------------------
module ipd_result_checker import ipd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	ipd_pix_if                       pixel_ch,
	ipd_res_if                       result_ch,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	input  logic [APB_DATA_BITS-1:0] prdata,
	input  logic                     pready,
	output int                       fail_count,
	output int                       pending,
	output int                       result_count,
	output int                       replaced_count,
	output int                       frames_closed
);

	localparam int LINE_DEPTH = MAX_WIDTH_DEF;
	localparam int PB         = PIXEL_BITS_DEF;

	typedef logic [PB-1:0] pix_t;

	typedef struct packed {
		pix_t pixel;
		logic replaced;
		logic row_end;
		logic frame_end;
		logic run_end;
	} filtered_t;

	pix_t               row_above  [LINE_DEPTH];
	pix_t               row_above2 [LINE_DEPTH];
	int unsigned        col_pos;
	int unsigned        row_pos;
	pix_t               tail_pixel;
	logic [FW_BITS-1:0] width_reg;
	logic [FH_BITS-1:0] height_reg;
	filtered_t          awaited_pixels [$];

	// Average the neighbours that differ, unless one of them matches the centre
	function automatic filtered_t judge_centre(input pix_t centre,
			input logic [3:0][PB-1:0] nbrs, input logic [3:0] present,
			input bit row_end, input bit frame_end);
		int unsigned sum;
		int unsigned cnt;
		bit          matched;
		filtered_t   res;
		sum     = 0;
		cnt     = 0;
		matched = 0;
		for (int i = 0; i < 4; i++) begin
			if (present[i]) begin
				if (nbrs[i] == centre) begin
					matched = 1;
				end else begin
					sum += nbrs[i];
					cnt++;
				end
			end
		end
		res.pixel     = centre;
		res.replaced  = 1'b0;
		if (!matched && cnt != 0) begin
			res.pixel    = pix_t'(sum / cnt);
			res.replaced = 1'b1;
		end
		res.row_end   = row_end;
		res.frame_end = frame_end;
		res.run_end   = 1'b0;
		return res;
	endfunction

	task automatic predict_filtered_pixels(input pix_t px);
		int unsigned          w;
		int unsigned          h;
		int unsigned          c;
		int unsigned          r;
		bit                   last_row;
		bit                   last_col;
		logic [3:0][PB-1:0]   nbrs;
		logic [3:0]           present;
		filtered_t            run [$];
		filtered_t            one;
		w = width_reg;
		if (w < 2) w = 2;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		h = height_reg;
		if (h < 2) h = 2;
		c = col_pos;
		r = row_pos;
		if (c > w - 1) c = w - 1;
		last_row = (r >= h - 1);
		last_col = (c == w - 1);

		// neighbour order: right, left, up, down
		if (r > 0) begin
			nbrs[0]    = (c + 1 < w) ? row_above[c + 1] : '0;
			present[0] = (c + 1 < w);
			nbrs[1]    = (c > 0) ? row_above2[c - 1] : '0;
			present[1] = (c > 0);
			nbrs[2]    = row_above2[c];
			present[2] = (r > 1);
			nbrs[3]    = px;
			present[3] = 1'b1;
			run.push_back(judge_centre(row_above[c], nbrs, present, last_col, 1'b0));
		end

		row_above2[c] = row_above[c];
		row_above[c]  = px;

		if (last_row) begin
			if (c > 0) begin
				nbrs[0]    = px;
				present[0] = 1'b1;
				nbrs[1]    = (c > 1) ? row_above[c - 2] : '0;
				present[1] = (c > 1);
				nbrs[2]    = row_above2[c - 1];
				present[2] = 1'b1;
				nbrs[3]    = '0;
				present[3] = 1'b0;
				run.push_back(judge_centre(tail_pixel, nbrs, present, 1'b0, 1'b0));
			end
			if (last_col) begin
				nbrs[0]    = '0;
				present[0] = 1'b0;
				nbrs[1]    = (c > 0) ? row_above[c - 1] : '0;
				present[1] = (c > 0);
				nbrs[2]    = row_above2[c];
				present[2] = 1'b1;
				nbrs[3]    = '0;
				present[3] = 1'b0;
				run.push_back(judge_centre(px, nbrs, present, 1'b1, 1'b1));
			end
			tail_pixel = px;
		end

		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : ((r + 1) & 32'hFFF);
		end else begin
			col_pos = c + 1;
		end

		for (int i = 0; i < run.size(); i++) begin
			one         = run[i];
			one.run_end = (i == run.size() - 1);
			awaited_pixels.push_back(one);
		end
	endtask

	task automatic compare_field(input string name, input logic [PB-1:0] want,
			input logic [PB-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		filtered_t want;
		if (awaited_pixels.size() == 0) begin
			$error("pixel_out: no result expected, got %0d", result_ch.pixel_out);
			fail_count++;
		end else begin
			want = awaited_pixels.pop_front();
			compare_field("pixel_out", want.pixel, result_ch.pixel_out);
			compare_field("was_replaced", PB'(want.replaced), PB'(result_ch.was_replaced));
			compare_field("end_of_row", PB'(want.row_end), PB'(result_ch.end_of_row));
			compare_field("end_of_frame", PB'(want.frame_end), PB'(result_ch.end_of_frame));
			compare_field("last_of_run", PB'(want.run_end), PB'(result_ch.last_of_run));
		end
		result_count++;
		if (result_ch.was_replaced === 1'b1) replaced_count++;
		if (result_ch.end_of_frame === 1'b1) frames_closed++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg      = FW_RESET;
			height_reg     = FH_RESET;
			col_pos        = 0;
			row_pos        = 0;
			tail_pixel     = '0;
			for (int i = 0; i < LINE_DEPTH; i++) begin
				row_above[i]  = '0;
				row_above2[i] = '0;
			end
			awaited_pixels.delete();
			fail_count     = 0;
			pending        = 0;
			result_count   = 0;
			replaced_count = 0;
			frames_closed  = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) check_result();
			if (pixel_ch.valid && pixel_ch.ready) predict_filtered_pixels(pixel_ch.pixel_in);
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[REG_IDX_LSB] == REG_FRAME_WIDTH) width_reg = pwdata[FW_BITS-1:0];
					else height_reg = pwdata[FH_BITS-1:0];
				end else if (prdata !== ((paddr[REG_IDX_LSB] == REG_FRAME_WIDTH) ?
						APB_DATA_BITS'(width_reg) : APB_DATA_BITS'(height_reg))) begin
					$error("prdata: expected %0d, got %0d",
						(paddr[REG_IDX_LSB] == REG_FRAME_WIDTH) ? width_reg : height_reg,
						prdata);
					fail_count++;
				end
			end
			pending = awaited_pixels.size();
		end
	end

endmodule

// ===== tb/isolated_pixel_despeckle_filter_tb.sv =====
// ----------------------------------------------------------------------------
// isolated_pixel_despeckle_filter_tb - stimulus and verdict for the filter
// Drives frames of pixels through the filter under changing frame sizes and
// traffic patterns; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module isolated_pixel_despeckle_filter_tb;
	import ipd_pkg::*;

	localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake anywhere
	localparam int HOLD_CYCLES   = 500;   // long output hold-off
	localparam int SETTLE_CYCLES = 12;    // item with no result still in flight
	localparam int DRAIN_CYCLES  = 20;
	localparam int RANDOM_ITEMS  = 230;
	localparam int FILL_WIDTH    = 64;    // wider than any later frame reaches
	localparam int PHASE_ITEMS   = 37;    // odd length so gaps drift over frames

	typedef enum logic [1:0] {
		PH_STEADY,
		PH_SOURCE_GAPS,
		PH_SINK_STALLS,
		PH_BOTH_IDLE
	} traffic_phase_t;

	// Hand-built 4 x 5 frame: isolated corners, edges and interior pixels,
	// a matched neighbour, a truncated average and both pixel extremes.
	localparam logic [0:19][7:0] SPOT_FRAME = {
		8'd0,  8'd10,  8'd10,  8'd255,
		8'd10, 8'd255, 8'd10,  8'd10,
		8'd0,  8'd10,  8'd10,  8'd10,
		8'd10, 8'd10,  8'd200, 8'd10,
		8'd7,  8'd3,   8'd10,  8'd255
	};

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int             fail_count;
	int             pending;
	int             result_count;
	int             replaced_count;
	int             frames_closed;
	int             items_sent;
	int             reg_writes;
	int             quiet_cycles;
	int             src_idle_pct;
	int             snk_stall_pct;
	bit             hold_request;
	traffic_phase_t phase;

	ipd_pix_if pix_if ();
	ipd_res_if res_if ();

	isolated_pixel_despeckle_filter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.pixel_stream  (pix_if),
		.result_stream (res_if),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	ipd_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.pixel_ch       (pix_if),
		.result_ch      (res_if),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.fail_count     (fail_count),
		.pending        (pending),
		.result_count   (result_count),
		.replaced_count (replaced_count),
		.frames_closed  (frames_closed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Bail out when nothing moves on any port for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
					(psel && penable && pready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Receiver: stall at the rate of the current phase, and once hold off
	// for a long stretch so that the filter backs up into its input.
	initial begin
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 0;
			end
			res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// One APB transfer: setup, access, then back to idle
	task automatic apb_transfer(input bit write, input logic idx,
			input logic [APB_DATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= APB_ADDR_BITS'(idx) << REG_IDX_LSB;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Write a register and read it back; the checker compares the read
	task automatic write_reg(input logic idx, input int value);
		apb_transfer(1'b1, idx, APB_DATA_BITS'(value));
		apb_transfer(1'b0, idx, '0);
		reg_writes++;
	endtask

	// Offer one item, with gaps as the current phase asks, and wait for it
	task automatic send_pixel(input logic [7:0] px);
		if (items_sent % PHASE_ITEMS == 0) begin
			phase = traffic_phase_t'((int'(phase) + 1) % 4);
			case (phase)
				PH_STEADY: begin
					src_idle_pct  = 0;
					snk_stall_pct = 0;
				end
				PH_SOURCE_GAPS: begin
					src_idle_pct  = 84;
					snk_stall_pct = 0;
				end
				PH_SINK_STALLS: begin
					src_idle_pct  = 0;
					snk_stall_pct = 84;
				end
				default: begin
					src_idle_pct  = 24;
					snk_stall_pct = 24;
				end
			endcase
		end
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(negedge clk);
		end
		pix_if.valid    <= 1'b1;
		pix_if.pixel_in <= px;
		do @(posedge clk); while (!pix_if.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Mostly a flat background with speckles, near misses and full-range noise
	function automatic logic [7:0] speckle_pixel(input logic [7:0] base);
		case ($urandom_range(0, 9))
			6, 7:    return 8'($urandom_range(0, 255));
			8:       return base + 8'd1;
			9:       return base - 8'd1;
			default: return base;
		endcase
	endfunction

	task automatic send_pixels(input int count);
		logic [7:0] base;
		base = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 1) * 255) :
			8'($urandom_range(0, 255));
		repeat (count) send_pixel(speckle_pixel(base));
	endtask

	// Drop valid and wait until every predicted result is out, then allow
	// for an item with no result still working through the pipeline.
	task automatic settle();
		pix_if.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int w_val;
		int h_val;
		int frame_len;
		int split;
		int random_start;

		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		pix_if.valid    = 1'b0;
		pix_if.pixel_in = '0;
		items_sent      = 0;
		reg_writes      = 0;
		quiet_cycles    = 0;
		hold_request    = 0;
		src_idle_pct    = 0;
		snk_stall_pct   = 0;
		phase           = PH_BOTH_IDLE;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Read the sizes straight out of reset
		apb_transfer(1'b0, REG_FRAME_WIDTH, '0);
		apb_transfer(1'b0, REG_FRAME_HEIGHT, '0);

		// Hand-built frame
		write_reg(REG_FRAME_WIDTH, 4);
		write_reg(REG_FRAME_HEIGHT, 5);
		for (int i = 0; i < 20; i++) send_pixel(SPOT_FRAME[i]);
		settle();

		// Wide frame at the smallest height (1 saturates to 2); this also
		// fills both line stores over every column that later frames reach.
		write_reg(REG_FRAME_WIDTH, FILL_WIDTH);
		write_reg(REG_FRAME_HEIGHT, 1);
		send_pixels(2 * FILL_WIDTH);
		settle();

		// Tallest height, then cut it mid-frame so the row counter lies
		// beyond the new last row
		write_reg(REG_FRAME_WIDTH, 2);
		write_reg(REG_FRAME_HEIGHT, 4095);
		send_pixels(40);
		settle();
		write_reg(REG_FRAME_HEIGHT, 0);
		send_pixels(6);
		settle();

		// Width below range, raised mid-row past the top of the range,
		// then lowered under the column counter
		write_reg(REG_FRAME_WIDTH, 1);
		write_reg(REG_FRAME_HEIGHT, 3);
		send_pixels(3);
		settle();
		write_reg(REG_FRAME_WIDTH, 2047);
		send_pixels(9);
		settle();
		write_reg(REG_FRAME_WIDTH, 5);
		send_pixels(17);
		settle();

		// Hold the output off for a long stretch while items keep coming
		write_reg(REG_FRAME_WIDTH, 8);
		write_reg(REG_FRAME_HEIGHT, 6);
		hold_request = 1;
		send_pixels(48);
		settle();

		// Random frames, small for the most part, some cut by a size change
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       w_val = $urandom_range(0, 1);
				1:       w_val = $urandom_range(9, 24);
				default: w_val = $urandom_range(2, 8);
			endcase
			case ($urandom_range(0, 9))
				0:       h_val = $urandom_range(0, 1);
				1:       h_val = $urandom_range(7, 10);
				default: h_val = $urandom_range(2, 5);
			endcase
			write_reg(REG_FRAME_WIDTH, w_val);
			write_reg(REG_FRAME_HEIGHT, h_val);
			frame_len = ((w_val < 2) ? 2 : w_val) * ((h_val < 2) ? 2 : h_val);
			if ($urandom_range(0, 3) == 0) begin
				split = $urandom_range(1, frame_len - 1);
				send_pixels(split);
				settle();
				if ($urandom_range(0, 1)) write_reg(REG_FRAME_WIDTH, $urandom_range(0, 12));
				else write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 8));
				send_pixels($urandom_range(1, 2 * frame_len));
			end else begin
				send_pixels(frame_len);
			end
			settle();
		end

		// Let the tail of the pipeline run out
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d pixel items, %0d filtered pixels (%0d replaced, %0d frames)",
			items_sent, result_count, replaced_count, frames_closed);
		$display("over %0d register writes: size extremes, mid-frame sizes, long hold-off",
			reg_writes);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ipd_pkg.sv
rtl/ipd_ifs.sv
rtl/ipd_cfg_regs.sv
rtl/ipd_ctrl.sv
rtl/ipd_datapath.sv
rtl/isolated_pixel_despeckle_filter.sv
rtl/ipd_checker.sv
tb/ipd_result_checker.sv
tb/isolated_pixel_despeckle_filter_tb.sv
